// ===== rtl/cbs_pkg.sv =====
`timescale 1ns / 1ps

package cbs_pkg;

    // Fixed geometry of the blit engine.
    localparam int PIXEL_BYTES     = 4;
    localparam int ADDR_WIDTH      = 48;
    localparam int MAX_DIM         = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 160;

    // Width of a pixel offset after scaling by the pixel size.
    localparam int OFF_W   = 37;
    localparam int SUM_W   = 32;

    typedef logic signed [15:0] coord_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DST_BASE   = 3'd0,
        REG_DST_PITCH  = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_SRC_BASE   = 3'd4,
        REG_SRC_PITCH  = 3'd5,
        REG_SRC_WIDTH  = 3'd6,
        REG_SRC_HEIGHT = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        OP_COPY = 1'b0,
        OP_MOVE = 1'b1
    } op_t;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] dst_base;
        logic [13:0]           dst_pitch;
        logic [12:0]           dst_width;
        logic [12:0]           dst_height;
        logic [ADDR_WIDTH-1:0] src_base;
        logic [13:0]           src_pitch;
        logic [12:0]           src_width;
        logic [12:0]           src_height;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [12:0] dst_x;
        logic [12:0] dst_y;
        logic [12:0] src_x;
        logic [12:0] src_y;
        logic [12:0] rect_w;
        logic [12:0] rect_h;
    } cmd_t;

    // Clipped geometry of one request.
    typedef struct packed {
        logic        is_move;
        logic        empty;
        logic        desc;
        coord_t      dst_px;
        coord_t      dst_py;
        coord_t      src_px;
        coord_t      src_py;
        logic [14:0] line_bytes;
        logic [12:0] line_count;
    } clip_t;

    // Pixel offsets of the first line in both buffers.
    typedef struct packed {
        logic        is_move;
        logic        empty;
        logic        desc;
        sum_t        dst_sum;
        sum_t        src_sum;
        logic [14:0] line_bytes;
        logic [12:0] line_count;
    } offs_t;

endpackage

// ===== rtl/clipped_blit_setup_core.sv =====
`timescale 1ns / 1ps

// Blit setup core: turns one blit request into the setup of a line-by-line
// DMA transfer (start addresses, bytes per line, line count, strides).
//
// Channels: the slave stream carries requests; s_tuser holds the operation
// (0 copy with clipping, 1 move within the destination buffer) and s_tdata
// the coordinates and rectangle size. The master stream carries one result
// request per input request; m_tuser holds the walk direction and the empty
// flag. The configuration port writes the eight buffer registers, one per
// cycle, and must only be used while no request is in flight.
//
// Pipeline and throughput: four register stages (input, clip, offset
// multiply, address add), passed in that order. One request is taken
// every cycle unless m_tready stalls the full pipeline; the pitch
// multiplier and the 48-bit base add each sit in a stage of their own.
//
// Reset clears every stage's valid flag and all configuration registers.
// When the receiver holds m_tready low the stages fill one by one; s_tready
// only falls once all four hold a request, so nothing is lost or repeated.

module clipped_blit_setup_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Request stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata from bit 0: dst_x[12:0], dst_y[25:13], src_x[38:26],
    // src_y[51:39], rect_w[64:52], rect_h[77:65], zero fill[79:78].
    input  logic [cbs_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: op[0].
    input  logic                            s_tuser,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata from bit 0: dst_start[47:0], src_start[95:48],
    // line_bytes[110:96], line_count[123:111], dst_stride[139:124],
    // src_stride[155:140], zero fill[159:156].
    output logic [cbs_pkg::OUT_DATA_W-1:0]  m_tdata,
    // m_tuser from bit 0: descending[0], empty_res[1].
    output logic [1:0]                      m_tuser
);
    import cbs_pkg::*;

    cfg_t cfg;

    cbs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Stage handshake: a stage may load when it is empty or its content
    // moves on in the same cycle.
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic a_ready, b_ready, c_ready, d_ready;

    assign d_ready  = !d_valid_reg || m_tready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;
    assign m_tvalid = d_valid_reg;

    // Stage A: the request as received.
    cmd_t a_reg, a_next;

    always_comb
    begin
        a_next.op     = op_t'(s_tuser);
        a_next.dst_x  = s_tdata[12:0];
        a_next.dst_y  = s_tdata[25:13];
        a_next.src_x  = s_tdata[38:26];
        a_next.src_y  = s_tdata[51:39];
        a_next.rect_w = s_tdata[64:52];
        a_next.rect_h = s_tdata[77:65];
    end

    // Stage B: clipped geometry.
    clip_t b_reg, b_next;

    cbs_clip u_clip (
        .cmd  (a_reg),
        .cfg  (cfg),
        .clip (b_next)
    );

    // Stage C: pixel offsets. A move takes both addresses in the destination
    // buffer, so its source side uses the destination pitch.
    offs_t c_reg, c_next;
    sum_t  dst_sum, src_sum;
    logic [13:0] src_side_pitch;

    assign src_side_pitch = b_reg.is_move ? cfg.dst_pitch : cfg.src_pitch;

    cbs_mac u_dst_mac (
        .pitch (cfg.dst_pitch),
        .x     (b_reg.dst_px),
        .y     (b_reg.dst_py),
        .sum   (dst_sum)
    );

    cbs_mac u_src_mac (
        .pitch (src_side_pitch),
        .x     (b_reg.src_px),
        .y     (b_reg.src_py),
        .sum   (src_sum)
    );

    always_comb
    begin
        c_next.is_move    = b_reg.is_move;
        c_next.empty      = b_reg.empty;
        c_next.desc       = b_reg.desc;
        c_next.dst_sum    = dst_sum;
        c_next.src_sum    = src_sum;
        c_next.line_bytes = b_reg.line_bytes;
        c_next.line_count = b_reg.line_count;
    end

    // Stage D: byte addresses, wrapping modulo the address space (zero for an
    // empty request), and the packed result.
    localparam logic signed [4:0] BPP_S = 5'(PIXEL_BYTES);

    logic signed [OFF_W-1:0] dst_off, src_off;
    logic [ADDR_WIDTH-1:0]   dst_start, src_start, src_side_base;
    logic [15:0]             dst_stride, src_stride;
    logic [OUT_DATA_W-1:0]   d_data_reg, d_data_next;
    logic [1:0]              d_user_reg, d_user_next;

    always_comb
    begin
        dst_off       = c_reg.dst_sum * BPP_S;
        src_off       = c_reg.src_sum * BPP_S;
        src_side_base = c_reg.is_move ? cfg.dst_base : cfg.src_base;
        dst_start     = cfg.dst_base
                      + {{(ADDR_WIDTH-OFF_W){dst_off[OFF_W-1]}}, dst_off};
        src_start     = src_side_base
                      + {{(ADDR_WIDTH-OFF_W){src_off[OFF_W-1]}}, src_off};
        if (c_reg.empty)
        begin
            dst_start = '0;
            src_start = '0;
        end
        dst_stride = 16'({3'b000, cfg.dst_pitch} * 17'(PIXEL_BYTES));
        src_stride = c_reg.is_move ? dst_stride
                   : 16'({3'b000, cfg.src_pitch} * 17'(PIXEL_BYTES));

        d_data_next = {4'b0000, src_stride, dst_stride, c_reg.line_count,
                       c_reg.line_bytes, src_start, dst_start};
        d_user_next = {c_reg.empty, c_reg.desc};
    end

    assign m_tdata = d_data_reg;
    assign m_tuser = d_user_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    // Payload registers load with their stage and need no reset.
    always_ff @(posedge clk)
    begin
        if (a_ready && s_tvalid)
        begin
            a_reg <= a_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_reg <= b_next;
        end
        if (c_ready && b_valid_reg)
        begin
            c_reg <= c_next;
        end
        if (d_ready && c_valid_reg)
        begin
            d_data_reg <= d_data_next;
            d_user_reg <= d_user_next;
        end
    end

endmodule

// ===== rtl/cbs_cfg_regs.sv =====
`timescale 1ns / 1ps

module cbs_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output cbs_pkg::cfg_t                cfg
);
    import cbs_pkg::*;

    cfg_t cfg_reg;

    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_DST_BASE:   cfg_reg.dst_base   <= cfg_wdata[ADDR_WIDTH-1:0];
                REG_DST_PITCH:  cfg_reg.dst_pitch  <= cfg_wdata[13:0];
                REG_DST_WIDTH:  cfg_reg.dst_width  <= cfg_wdata[12:0];
                REG_DST_HEIGHT: cfg_reg.dst_height <= cfg_wdata[12:0];
                REG_SRC_BASE:   cfg_reg.src_base   <= cfg_wdata[ADDR_WIDTH-1:0];
                REG_SRC_PITCH:  cfg_reg.src_pitch  <= cfg_wdata[13:0];
                REG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_wdata[12:0];
                REG_SRC_HEIGHT: cfg_reg.src_height <= cfg_wdata[12:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== rtl/cbs_clip.sv =====
`timescale 1ns / 1ps

module cbs_clip (
    input  cbs_pkg::cmd_t  cmd,
    input  cbs_pkg::cfg_t  cfg,
    output cbs_pkg::clip_t clip
);
    import cbs_pkg::*;

    function automatic coord_t smax(coord_t a, coord_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic coord_t smin(coord_t a, coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t sat_dim(logic [12:0] v);
        return (v > 13'(MAX_DIM)) ? coord_t'(MAX_DIM) : coord_t'({3'b000, v});
    endfunction

    function automatic coord_t sext(logic [12:0] v);
        return {{3{v[12]}}, v};
    endfunction

    coord_t dx, dy, sx, sy, w, h;
    coord_t ox, oy, x0, y0, x1, y1;
    coord_t up, span, lines;
    logic   copy_empty, move_empty, move_desc, is_move, empty;

    always_comb
    begin
        dx = sext(cmd.dst_x);
        dy = sext(cmd.dst_y);
        sx = sext(cmd.src_x);
        sy = sext(cmd.src_y);
        w  = sat_dim(cmd.rect_w);
        h  = sat_dim(cmd.rect_h);

        // Copy: intersect the shifted rectangle, the destination screen and
        // the shifted source buffer.
        ox = dx - sx;
        oy = dy - sy;
        x0 = smax(smax(16'sd0, ox), dx);
        y0 = smax(smax(16'sd0, oy), dy);
        x1 = smin(smin(sat_dim(cfg.dst_width), ox + sat_dim(cfg.src_width)), dx + w);
        y1 = smin(smin(sat_dim(cfg.dst_height), oy + sat_dim(cfg.src_height)), dy + h);
        copy_empty = (x1 <= x0) || (y1 <= y0);

        // Move: overlapping areas are walked bottom up when the destination
        // is not above the source.
        move_desc  = !(dy < sy);
        move_empty = (w == 16'sd0) || (h == 16'sd0);
        up         = move_desc ? (h - 16'sd1) : 16'sd0;

        is_move = (cmd.op == OP_MOVE);
        empty   = is_move ? move_empty : copy_empty;
        span    = is_move ? w : (x1 - x0);
        lines   = is_move ? h : (y1 - y0);

        clip.is_move = is_move;
        clip.empty   = empty;
        clip.desc    = is_move && move_desc && !empty;
        clip.dst_px  = is_move ? dx : x0;
        clip.dst_py  = is_move ? (dy + up) : y0;
        clip.src_px  = is_move ? sx : (x0 - ox);
        clip.src_py  = is_move ? (sy + up) : (y0 - oy);
        clip.line_bytes = empty ? 15'd0
                                : 15'({3'b000, span} * 19'(PIXEL_BYTES));
        clip.line_count = empty ? 13'd0 : lines[12:0];
    end

endmodule

// ===== rtl/cbs_mac.sv =====
`timescale 1ns / 1ps

module cbs_mac (
    input  logic [13:0]     pitch,
    input  cbs_pkg::coord_t x,
    input  cbs_pkg::coord_t y,
    output cbs_pkg::sum_t   sum
);
    import cbs_pkg::*;

    logic signed [14:0] pitch_s;
    logic signed [30:0] prod;

    // Pixel offset of (x, y) in a buffer: pitch * y + x.
    always_comb
    begin
        pitch_s = {1'b0, pitch};
        prod    = pitch_s * y;
        sum     = {prod[30], prod} + {{(SUM_W-16){x[15]}}, x};
    end

endmodule
